@@ src/lzwd_pkg.sv @@
// Shared types and constants for the LZW code decoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lzwd_pkg;

  localparam int CODE_W    = 12;
  localparam int NFC_W     = 13;
  localparam int DICT_SIZE = 4096;
  localparam int MAX_LEN   = 64;
  localparam int LEN_W     = 7;
  localparam int POS_W     = 6;
  localparam int BYTE_W    = 8;

  localparam logic [CODE_W-1:0] LIT_MAX   = 12'd256;
  localparam logic [NFC_W-1:0]  FIRST_DEF = 13'd257;

  // one dictionary entry: prefix code, last byte, string length
  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
    logic [LEN_W-1:0]  len;
  } lzwd_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_WALK,
    S_COMMIT,
    S_EMIT,
    S_ERR
  } lzwd_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic len_chk;
    logic walk;
    logic commit;
    logic emit_adv;
    logic show_err;
  } lzwd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early_reject;
    logic len_reject;
    logic walk_done;
    logic emit_last;
  } lzwd_sts_t;

endpackage

@@ src/lzwd_ifs.sv @@
// Handshake channel interfaces: code beats in, byte beats out.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

interface lzwd_code_if;
  import lzwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_word;
  modport source (output valid, output code_word, input ready);
  modport sink   (input valid, input code_word, output ready);
endinterface

interface lzwd_byte_if;
  import lzwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  logic              code_error;
  modport source (output valid, output data_byte, output last_byte, output code_error,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input code_error,
                  output ready);
endinterface

@@ src/lzwd_ctrl.sv @@
// Sequencer for the LZW decoder: accept, length check, chain walk, commit, emit.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lzwd_pkg::lzwd_sts_t sts,
  output lzwd_pkg::lzwd_cmd_t cmd
);
  import lzwd_pkg::*;

  lzwd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.early_reject ? S_ERR : S_LEN;
        end
      end
      S_LEN: begin
        cmd.len_chk = 1'b1;
        state_nxt   = sts.len_reject ? S_ERR : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        out_valid    = 1'b1;
        cmd.emit_adv = out_ready;
        if (out_ready && sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        out_valid    = 1'b1;
        cmd.show_err = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/lzwd_dpath.sv @@
// Datapath of the LZW decoder: dictionary memory, reverse stack, stream state.
// Depends on lzwd_pkg; driven by lzwd_ctrl.
`timescale 1ns / 1ps

module lzwd_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lzwd_pkg::CODE_W-1:0] code_word,
  input  lzwd_pkg::lzwd_cmd_t         cmd,
  output lzwd_pkg::lzwd_sts_t         sts,
  output logic [lzwd_pkg::BYTE_W-1:0] data_byte,
  output logic                        last_byte,
  output logic                        code_error
);
  import lzwd_pkg::*;

  lzwd_entry_t dict_mem [DICT_SIZE];
  logic [BYTE_W-1:0] stk_mem [MAX_LEN];

  // stream state
  logic [NFC_W-1:0]  nfc_r;
  logic [CODE_W-1:0] prev_code_r;
  logic [BYTE_W-1:0] prev_first_r;
  logic [LEN_W-1:0]  prev_len_r;
  logic              started_r;

  // per-code working registers
  logic [CODE_W-1:0] code_r;
  logic              kwk_r;
  logic [CODE_W-1:0] walk_cur_r;
  logic [POS_W-1:0]  pos_r;
  logic [LEN_W-1:0]  total_r;
  logic [BYTE_W-1:0] first_byte_r;
  logic [POS_W-1:0]  emit_idx_r;
  lzwd_entry_t       dict_q_r;
  logic [BYTE_W-1:0] stk_q_r;

  logic              full;
  logic              kwk_in;
  logic [NFC_W-1:0]  code_ext;
  logic              dict_rd_en;
  logic [CODE_W-1:0] dict_rd_addr;
  logic              dict_wr_en;
  lzwd_entry_t       dict_wr_data;
  logic              stk_wr_en;
  logic [POS_W-1:0]  stk_wr_addr;
  logic [BYTE_W-1:0] stk_wr_data;
  logic              stk_rd_en;
  logic [POS_W-1:0]  stk_rd_addr;
  logic [LEN_W-1:0]  len_w;
  logic [LEN_W:0]    total;
  logic              walk_lit;
  logic [CODE_W-1:0] walk_m1;
  logic [BYTE_W-1:0] walk_byte;
  logic [LEN_W-1:0]  idx_p1;

  assign full     = nfc_r >= NFC_W'(DICT_SIZE);
  assign code_ext = {1'b0, code_word};
  assign kwk_in   = started_r && (code_ext == nfc_r);

  assign sts.early_reject = (code_word == '0)
                         || (!started_r && (code_word > LIT_MAX))
                         || (started_r && (code_ext > nfc_r))
                         || (kwk_in && full);

  // string length of the code being unwound, plus one for the repeated byte
  always_comb begin
    if (kwk_r) begin
      len_w = prev_len_r;
    end else if (walk_cur_r <= LIT_MAX) begin
      len_w = LEN_W'(1);
    end else begin
      len_w = dict_q_r.len;
    end
  end
  assign total          = {1'b0, len_w} + {{LEN_W{1'b0}}, kwk_r};
  assign sts.len_reject = (len_w == '0) || (total > (LEN_W+1)'(MAX_LEN));

  assign walk_lit      = walk_cur_r <= LIT_MAX;
  assign walk_m1       = walk_cur_r - CODE_W'(1);
  assign walk_byte     = walk_lit ? walk_m1[BYTE_W-1:0] : dict_q_r.suffix;
  assign sts.walk_done = walk_lit || (pos_r == '0);

  assign idx_p1        = {1'b0, emit_idx_r} + LEN_W'(1);
  assign sts.emit_last = idx_p1 == total_r;

  // dictionary port control
  always_comb begin
    dict_rd_en   = 1'b0;
    dict_rd_addr = dict_q_r.prefix;
    if (cmd.accept) begin
      dict_rd_en   = 1'b1;
      dict_rd_addr = kwk_in ? prev_code_r : code_word;
    end else if (cmd.walk && !sts.walk_done) begin
      dict_rd_en = 1'b1;
    end
  end
  assign dict_wr_en          = cmd.commit && started_r && !full;
  assign dict_wr_data.prefix = prev_code_r;
  assign dict_wr_data.suffix = first_byte_r;
  assign dict_wr_data.len    = prev_len_r + LEN_W'(1);

  // stack port control
  always_comb begin
    stk_wr_en   = 1'b0;
    stk_wr_addr = pos_r;
    stk_wr_data = walk_byte;
    if (cmd.len_chk) begin
      stk_wr_en   = kwk_r && !sts.len_reject;
      stk_wr_addr = len_w[POS_W-1:0];
      stk_wr_data = prev_first_r;
    end else if (cmd.walk) begin
      stk_wr_en = 1'b1;
    end
  end
  assign stk_rd_en   = cmd.commit || cmd.emit_adv;
  assign stk_rd_addr = cmd.commit ? '0 : idx_p1[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (dict_wr_en) begin
      dict_mem[nfc_r[CODE_W-1:0]] <= dict_wr_data;
    end
    if (dict_rd_en) begin
      dict_q_r <= dict_mem[dict_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stk_q_r <= stk_mem[stk_rd_addr];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r     <= code_word;
      kwk_r      <= kwk_in;
      walk_cur_r <= kwk_in ? prev_code_r : code_word;
    end
    if (cmd.len_chk) begin
      total_r <= total[LEN_W-1:0];
      pos_r   <= POS_W'(len_w - LEN_W'(1));
    end
    if (cmd.walk) begin
      if (sts.walk_done) begin
        first_byte_r <= walk_byte;
      end else begin
        walk_cur_r <= dict_q_r.prefix;
        pos_r      <= pos_r - POS_W'(1);
      end
    end
    if (cmd.commit) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_adv) begin
      emit_idx_r <= idx_p1[POS_W-1:0];
    end
  end

  // stream state, updated once per committed (not rejected) code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfc_r        <= FIRST_DEF;
      prev_code_r  <= '0;
      prev_first_r <= '0;
      prev_len_r   <= '0;
      started_r    <= 1'b0;
    end else if (cmd.commit) begin
      if (dict_wr_en) begin
        nfc_r <= nfc_r + NFC_W'(1);
      end
      prev_code_r  <= code_r;
      prev_first_r <= first_byte_r;
      prev_len_r   <= total_r;
      started_r    <= 1'b1;
    end
  end

  assign data_byte  = cmd.show_err ? '0 : stk_q_r;
  assign last_byte  = cmd.show_err ? 1'b1 : sts.emit_last;
  assign code_error = cmd.show_err;

endmodule

@@ src/lzw_code_decoder.sv @@
// Top level of the LZW code decoder: controller plus datapath.
// Depends on lzwd_pkg, lzwd_ifs, lzwd_ctrl and lzwd_dpath.
//
//   channel  dir  beat payload                          meaning
//   in_ch    in   code_word[11:0]                       one LZW code
//   out_ch   out  data_byte[7:0] last_byte code_error   one byte of the string
//
// An L-byte code goes through accept, length check, one walk step per byte of
// the unwound string (a dictionary read on each but the last), commit, then L
// byte beats. A rejected code goes to the error state from accept or from the
// length check and gives one error beat.
// Reset is synchronous, active low, and clears the controller state and the stream state only.
// A stall on out_ch holds the current beat; in_ch stays not ready until the last beat is taken.
`timescale 1ns / 1ps

module lzw_code_decoder (
  input logic        clk,
  input logic        rst_n,
  lzwd_code_if.sink  in_ch,
  lzwd_byte_if.source out_ch
);
  import lzwd_pkg::*;

  lzwd_cmd_t cmd;
  lzwd_sts_t sts;

  // sequencer: owns the handshakes, steps the datapath
  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: dictionary, reverse stack and the output byte register
  lzwd_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .code_word  (in_ch.code_word),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (out_ch.data_byte),
    .last_byte  (out_ch.last_byte),
    .code_error (out_ch.code_error)
  );

endmodule
